>>> rtl/dnpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dnpm_pkg;

	// base-class mask bits: A, C, G, T/U, gap
	localparam int CLS_W = 5;
	typedef logic [CLS_W-1:0] cls_t;

	localparam cls_t CLS_A   = 5'b00001;
	localparam cls_t CLS_C   = 5'b00010;
	localparam cls_t CLS_G   = 5'b00100;
	localparam cls_t CLS_T   = 5'b01000;
	localparam cls_t CLS_GAP = 5'b10000;

	// configuration port geometry
	localparam int CFG_INDEX_W    = 3;
	localparam int CFG_DATA_W     = 64;
	localparam int LEN_REG_W      = 6;
	localparam int NUM_CHAR_REGS  = 4;
	localparam int CHARS_PER_WORD = 8;
	localparam int SYMBOL_W       = 8;
	localparam int START_W        = 32;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_PATTERN_LENGTH  = 3'd0;
	localparam cfg_index_t REG_PATTERN_CHARS_0 = 3'd1;
	localparam cfg_index_t REG_PATTERN_CHARS_1 = 3'd2;
	localparam cfg_index_t REG_PATTERN_CHARS_2 = 3'd3;
	localparam cfg_index_t REG_PATTERN_CHARS_3 = 3'd4;

	// one configuration write
	typedef struct packed {
		logic                  wr_en;
		cfg_index_t            index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// case-insensitive IUPAC code to class mask, anything unknown is a gap
	function automatic cls_t class_of(input logic [SYMBOL_W-1:0] ch);
		logic [SYMBOL_W-1:0] up;
		cls_t                cls;
		up = ch;
		if (ch >= "a" && ch <= "z") begin
			up = ch - 8'd32;
		end
		case (up)
			"A":     cls = CLS_A;
			"C":     cls = CLS_C;
			"G":     cls = CLS_G;
			"T":     cls = CLS_T;
			"U":     cls = CLS_T;
			"M":     cls = CLS_A | CLS_C;
			"R":     cls = CLS_A | CLS_G;
			"W":     cls = CLS_A | CLS_T;
			"S":     cls = CLS_C | CLS_G;
			"Y":     cls = CLS_C | CLS_T;
			"K":     cls = CLS_G | CLS_T;
			"V":     cls = CLS_A | CLS_C | CLS_G;
			"H":     cls = CLS_A | CLS_C | CLS_T;
			"D":     cls = CLS_A | CLS_G | CLS_T;
			"B":     cls = CLS_C | CLS_G | CLS_T;
			"N":     cls = CLS_A | CLS_C | CLS_G | CLS_T;
			default: cls = CLS_GAP;
		endcase
		return cls;
	endfunction

endpackage

`default_nettype wire

>>> rtl/dnpm_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module dnpm_cfg_regs #(
	parameter int MAX_PATTERN = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  dnpm_pkg::cfg_wr_t            cfg,
	output dnpm_pkg::cls_t               aligned [MAX_PATTERN],
	output logic [MAX_PATTERN-1:0]       in_use,
	output logic [$clog2(MAX_PATTERN+1)-1:0] len
);

	import dnpm_pkg::*;

	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic                     len_we;
	logic [NUM_CHAR_REGS-1:0] word_we;
	logic [LEN_REG_W-1:0]     len_raw;
	logic [LW-1:0]            len_d;
	logic [LW-1:0]            len_q;
	cls_t                     pat_q [MAX_PATTERN];
	cls_t                     aligned_d [MAX_PATTERN];
	logic [MAX_PATTERN-1:0]   in_use_d;
	cls_t                     aligned_q [MAX_PATTERN];
	logic [MAX_PATTERN-1:0]   in_use_q;

	// register index decode
	always_comb begin
		len_we  = 1'b0;
		word_we = '0;
		if (cfg.wr_en) begin
			unique case (cfg.index)
				REG_PATTERN_LENGTH:  len_we     = 1'b1;
				REG_PATTERN_CHARS_0: word_we[0] = 1'b1;
				REG_PATTERN_CHARS_1: word_we[1] = 1'b1;
				REG_PATTERN_CHARS_2: word_we[2] = 1'b1;
				REG_PATTERN_CHARS_3: word_we[3] = 1'b1;
				default: begin
				end
			endcase
		end
	end

	// length clamped to 1..MAX_PATTERN at write time
	assign len_raw = cfg.data[LEN_REG_W-1:0];

	always_comb begin
		if (len_raw == '0) begin
			len_d = LW'(1);
		end else if (len_raw > LEN_REG_W'(MAX_PATTERN)) begin
			len_d = LW'(MAX_PATTERN);
		end else begin
			len_d = LW'(len_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LW'(1);
		end else if (len_we) begin
			len_q <= len_d;
		end
	end

	// pattern characters kept as class masks
	for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_pat
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pat_q[p] <= CLS_GAP;
			end else if (word_we[p / CHARS_PER_WORD]) begin
				pat_q[p] <= class_of(cfg.data[(p % CHARS_PER_WORD) * 8 +: 8]);
			end
		end
	end

	// pattern reversed onto history order: entry e meets pattern position len-1-e
	for (genvar e = 0; e < MAX_PATTERN; e++) begin : g_align
		localparam logic [LW-1:0] E = LW'(e);
		logic [LW-1:0] off;
		assign off          = len_q - E - LW'(1);
		assign in_use_d[e]  = (E < len_q);
		assign aligned_d[e] = in_use_d[e] ? pat_q[off[PW-1:0]] : CLS_GAP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < MAX_PATTERN; e++) begin
				aligned_q[e] <= CLS_GAP;
			end
			in_use_q <= MAX_PATTERN'(1);
		end else begin
			for (int e = 0; e < MAX_PATTERN; e++) begin
				aligned_q[e] <= aligned_d[e];
			end
			in_use_q <= in_use_d;
		end
	end

	assign aligned = aligned_q;
	assign in_use  = in_use_q;
	assign len     = len_q;

endmodule

`default_nettype wire

>>> rtl/dnpm_window.sv
`timescale 1ns / 1ps
`default_nettype none

module dnpm_window #(
	parameter int MAX_PATTERN = 32,
	parameter int INDEX_WIDTH = 32
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire [dnpm_pkg::SYMBOL_W-1:0]      symbol,
	input  wire                               restart,
	input  wire                               advance,
	output logic                              valid_s1,
	output dnpm_pkg::cls_t                    hist [MAX_PATTERN],
	output logic [INDEX_WIDTH-1:0]            count
);

	import dnpm_pkg::*;

	localparam logic [INDEX_WIDTH-1:0] COUNT_TOP = {INDEX_WIDTH{1'b1}};

	logic                   accept;
	logic [INDEX_WIDTH-1:0] count_base;
	cls_t                   hist_q [MAX_PATTERN];
	logic [INDEX_WIDTH-1:0] count_q;

	// a new beat enters when the stage is empty or the held one moves on
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// history shift, cleared on restart before the new mask goes in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				hist_q[k] <= '0;
			end
		end else if (accept) begin
			hist_q[0] <= class_of(symbol);
			for (int k = 1; k < MAX_PATTERN; k++) begin
				hist_q[k] <= restart ? '0 : hist_q[k-1];
			end
		end
	end

	// saturating position count
	assign count_base = restart ? '0 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= (count_base == COUNT_TOP) ? count_base : count_base + 1'b1;
		end
	end

	assign hist  = hist_q;
	assign count = count_q;

	a_restart_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && restart |=> count_q == INDEX_WIDTH'(1))
		else $error("count not one after restart");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !restart && count_q != COUNT_TOP |=> count_q == $past(count_q) + 1'b1)
		else $error("count did not step");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("count moved without a beat");

endmodule

`default_nettype wire

>>> rtl/dnpm_match.sv
`timescale 1ns / 1ps
`default_nettype none

module dnpm_match #(
	parameter int MAX_PATTERN = 32,
	parameter int INDEX_WIDTH = 32
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               valid_s1,
	input  dnpm_pkg::cls_t                    hist [MAX_PATTERN],
	input  wire [INDEX_WIDTH-1:0]             count,
	input  dnpm_pkg::cls_t                    aligned [MAX_PATTERN],
	input  wire [MAX_PATTERN-1:0]             in_use,
	input  wire [$clog2(MAX_PATTERN+1)-1:0]   len,
	output logic                              advance,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [dnpm_pkg::START_W-1:0]      m_tdata
);

	import dnpm_pkg::*;

	logic                   hit;
	logic                   enough;
	logic [INDEX_WIDTH-1:0] len_ext;
	logic [INDEX_WIDTH-1:0] start_full;
	logic                   m_valid_q;
	logic [START_W-1:0]     m_data_q;

	// every position in use must share a class bit
	always_comb begin
		hit = 1'b1;
		for (int e = 0; e < MAX_PATTERN; e++) begin
			if (in_use[e] && ((aligned[e] & hist[e]) == '0)) begin
				hit = 1'b0;
			end
		end
	end

	assign len_ext    = INDEX_WIDTH'(len);
	assign enough     = (count >= len_ext);
	assign start_full = count - len_ext;

	// result register, freed when empty or taken
	assign advance = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= valid_s1 && enough && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && enough && hit) begin
			m_data_q <= START_W'(start_full);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	a_rise_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1) && $past(count) >= INDEX_WIDTH'(len))
		else $error("result without a full window");

	a_rise_index: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> m_tdata == START_W'($past(count) - INDEX_WIDTH'(len)))
		else $error("start index does not follow count");

endmodule

`default_nettype wire

>>> rtl/degenerate_nucleotide_pattern_match.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming IUPAC pattern matcher: one text character per beat on the slave
// side (tuser set marks the first character of a new text), one start index
// per fully matching window on the master side. One character is taken every
// cycle while s_tready is high. Each result passes through the history shift
// register stage, then the parallel window compare into the result register.
// A stalled result holds the history stage, and input stops only while both
// stages are full. Configuration writes take effect once the pattern and
// length registers are written and the pattern is re-aligned to the current
// length; write only while no characters are in flight.

module degenerate_nucleotide_pattern_match #(
	parameter int MAX_PATTERN = 32,
	parameter int INDEX_WIDTH = 32
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// configuration write port
	input  wire                                 cfg_wr_en,
	input  wire [dnpm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire [dnpm_pkg::CFG_DATA_W-1:0]      cfg_data,
	// text in
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire [7:0]                           s_tdata,  // [7:0] symbol
	input  wire [0:0]                           s_tuser,  // [0] restart
	// matches out
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [31:0]                         m_tdata   // [31:0] start_index
);

	import dnpm_pkg::*;

	localparam int LW = $clog2(MAX_PATTERN + 1);

	cfg_wr_t                cfg_wr;
	cls_t                   aligned [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] in_use;
	logic [LW-1:0]          len;
	logic                   advance;
	logic                   valid_s1;
	cls_t                   hist [MAX_PATTERN];
	logic [INDEX_WIDTH-1:0] count;

	assign cfg_wr = '{wr_en: cfg_wr_en, index: cfg_index, data: cfg_data};

	// pattern registers and alignment
	dnpm_cfg_regs #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_wr),
		.aligned (aligned),
		.in_use  (in_use),
		.len     (len)
	);

	// text history and position count
	dnpm_window #(
		.MAX_PATTERN (MAX_PATTERN),
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.symbol   (s_tdata),
		.restart  (s_tuser[0]),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.hist     (hist),
		.count    (count)
	);

	// window compare and result register
	dnpm_match #(
		.MAX_PATTERN (MAX_PATTERN),
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.hist     (hist),
		.count    (count),
		.aligned  (aligned),
		.in_use   (in_use),
		.len      (len),
		.advance  (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire
